@@ design/dqm_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// dqm_pkg : shared types and constants for the process deque
// Record layout, transaction structs, operation and status codes, and the
// modular slot arithmetic of the ring store.
// ----------------------------------------------------------------------------
package dqm_pkg;

   localparam int DEPTH       = 16;
   localparam int IDX_W       = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W       = $clog2(DEPTH + 1);
   localparam int ID_W        = 32;
   localparam int TIME_W      = 16;
   localparam int REC_W       = ID_W + TIME_W;
   localparam int SUM_W       = TIME_W + IDX_W;
   localparam int FRAC_W      = 8;
   localparam int DIVD_W      = SUM_W + FRAC_W;
   localparam int STEP_W      = $clog2(DIVD_W + 1);
   localparam int MEAN_W      = 24;
   localparam int COUNT_OUT_W = 5;
   localparam int OP_W        = 3;
   localparam int STATUS_W    = 2;

   typedef enum logic [OP_W-1:0] {
      OP_PUSH_FRONT = 3'd0,
      OP_PUSH_BACK  = 3'd1,
      OP_POP_FRONT  = 3'd2,
      OP_POP_BACK   = 3'd3,
      OP_QUERY      = 3'd4
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_EXEC,
      S_POP_DATA,
      S_RD_FRONT,
      S_RD_BACK,
      S_CAP_BACK,
      S_DIV_WAIT
   } state_type;

   typedef struct packed {
      logic [OP_W-1:0]   operation;
      logic [ID_W-1:0]   process_id;
      logic [TIME_W-1:0] run_time;
   } req_type;

   typedef struct packed {
      logic [ID_W-1:0]        front_id;
      logic [TIME_W-1:0]      front_time;
      logic [ID_W-1:0]        back_id;
      logic [TIME_W-1:0]      back_time;
      logic [COUNT_OUT_W-1:0] entry_count;
      logic [MEAN_W-1:0]      mean_time;
      logic [STATUS_W-1:0]    status;
   } rsp_type;

   typedef struct packed {
      logic [ID_W-1:0]   rec_id;
      logic [TIME_W-1:0] rec_time;
   } record_type;

   // (base + off) mod DEPTH for off up to DEPTH, where one subtract wraps it
   function automatic logic [IDX_W-1:0] slot_add(input logic [IDX_W-1:0] base,
                                                 input logic [CNT_W-1:0] off);
      logic [CNT_W:0] s;
      s = (CNT_W+1)'(base) + (CNT_W+1)'(off);
      if (s >= (CNT_W+1)'(DEPTH)) begin
         s = s - (CNT_W+1)'(DEPTH);
      end
      return IDX_W'(s);
   endfunction

endpackage
`default_nettype wire

@@ design/process_deque_with_mean_unit.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// process_deque_with_mean_unit : bounded deque of process records with mean
// Ring store of records with push/pop at both ends, query, and a running
// mean run time computed by a serial divider.
// ----------------------------------------------------------------------------
// Each transaction is accepted when start is high and busy is low, and yields
// exactly one result on rsp_data, marked by rsp_strobe for a single cycle; the
// receiver cannot stall it. When records remain after the operation, the
// result waits on the serial divider, which produces one bit of the 28-bit
// quotient per cycle, of which mean_time takes the low 24 bits; when the queue
// is left empty the divider is not used. A pop adds the S_POP_DATA state.
// busy stays high from accept until the edge that takes the result.
module process_deque_with_mean_unit
   import dqm_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   output logic         busy,
   input  wire req_type req_data,
   output logic         rsp_strobe,
   output rsp_type      rsp_data
);

   state_type        state_ff, state_in;
   req_type          req_ff, req_in;
   logic [IDX_W-1:0] head_ff, head_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [SUM_W-1:0] sum_ff, sum_in;
   status_type       status_ff, status_in;
   rsp_type          rsp_ff, rsp_in;
   logic             rsp_strobe_ff, rsp_strobe_in;

   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;
   logic [REC_W-1:0] wr_data;
   logic [IDX_W-1:0] rd_addr;
   logic [REC_W-1:0] rd_raw;
   record_type       rd_rec;

   logic              div_start;
   logic              div_done;
   logic [DIVD_W-1:0] div_quotient;
   logic [IDX_W-1:0]  back_slot;
   logic              is_full;
   logic              is_empty;

   dqm_ram #(
      .DATA_W    (REC_W),
      .RAM_DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_raw)
   );

   dqm_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend ({sum_ff, {FRAC_W{1'b0}}}),
      .divisor  (count_ff),
      .done     (div_done),
      .quotient (div_quotient)
   );

   assign rd_rec    = record_type'(rd_raw);
   assign back_slot = slot_add(head_ff, count_ff - CNT_W'(1));
   assign is_full   = (count_ff >= CNT_W'(DEPTH));
   assign is_empty  = (count_ff == '0);
   assign wr_data   = {req_ff.process_id, req_ff.run_time};

   always_comb begin
      state_in      = state_ff;
      req_in        = req_ff;
      head_in       = head_ff;
      count_in      = count_ff;
      sum_in        = sum_ff;
      status_in     = status_ff;
      rsp_in        = rsp_ff;
      rsp_strobe_in = 1'b0;
      wr_en         = 1'b0;
      wr_addr       = slot_add(head_ff, count_ff);
      rd_addr       = head_ff;
      div_start     = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               req_in    = req_data;
               status_in = ST_OK;
               state_in  = S_EXEC;
            end
         end
         S_EXEC: begin
            state_in = S_RD_FRONT;
            case (req_ff.operation) inside
               OP_PUSH_FRONT, OP_PUSH_BACK: begin
                  if (is_full) begin
                     status_in = ST_FULL;
                  end else begin
                     wr_en = 1'b1;
                     if (req_ff.operation == OP_PUSH_FRONT) begin
                        wr_addr = slot_add(head_ff, CNT_W'(DEPTH - 1));
                        head_in = wr_addr;
                     end
                     count_in = count_ff + CNT_W'(1);
                     sum_in   = sum_ff + SUM_W'(req_ff.run_time);
                  end
               end
               OP_POP_FRONT, OP_POP_BACK: begin
                  if (is_empty) begin
                     status_in = ST_EMPTY;
                  end else begin
                     // fetch the leaving record so its time can be dropped
                     if (req_ff.operation == OP_POP_FRONT) begin
                        rd_addr = head_ff;
                        head_in = slot_add(head_ff, CNT_W'(1));
                     end else begin
                        rd_addr = back_slot;
                     end
                     count_in = count_ff - CNT_W'(1);
                     state_in = S_POP_DATA;
                  end
               end
               default: begin
                  if (is_empty) begin
                     status_in = ST_EMPTY;
                  end
               end
            endcase
         end
         S_POP_DATA: begin
            sum_in   = sum_ff - SUM_W'(rd_rec.rec_time);
            state_in = S_RD_FRONT;
         end
         S_RD_FRONT: begin
            if (is_empty) begin
               rsp_in             = '0;
               rsp_in.entry_count = COUNT_OUT_W'(count_ff);
               rsp_in.status      = status_ff;
               rsp_strobe_in      = 1'b1;
               state_in           = S_IDLE;
            end else begin
               rd_addr   = head_ff;
               div_start = 1'b1;
               state_in  = S_RD_BACK;
            end
         end
         S_RD_BACK: begin
            rsp_in.front_id   = rd_rec.rec_id;
            rsp_in.front_time = rd_rec.rec_time;
            rd_addr           = back_slot;
            state_in          = S_CAP_BACK;
         end
         S_CAP_BACK: begin
            rsp_in.back_id   = rd_rec.rec_id;
            rsp_in.back_time = rd_rec.rec_time;
            state_in         = S_DIV_WAIT;
         end
         S_DIV_WAIT: begin
            if (div_done) begin
               rsp_in.mean_time   = MEAN_W'(div_quotient);
               rsp_in.entry_count = COUNT_OUT_W'(count_ff);
               rsp_in.status      = status_ff;
               rsp_strobe_in      = 1'b1;
               state_in           = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         head_ff       <= '0;
         count_ff      <= '0;
         sum_ff        <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         head_ff       <= head_in;
         count_ff      <= count_in;
         sum_ff        <= sum_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      req_ff    <= req_in;
      status_ff <= status_in;
      rsp_ff    <= rsp_in;
   end

   assign busy       = (state_ff != S_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

endmodule
`default_nettype wire

@@ design/dqm_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// dqm_ram : generic single-write, single-read RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module dqm_ram #(
   parameter int DATA_W    = 8,
   parameter int RAM_DEPTH = 16
) (
   input  wire logic                                            clock,
   input  wire logic                                            wr_en,
   input  wire logic [((RAM_DEPTH > 1) ? $clog2(RAM_DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [DATA_W-1:0]                               wr_data,
   input  wire logic [((RAM_DEPTH > 1) ? $clog2(RAM_DEPTH) : 1)-1:0] rd_addr,
   output logic      [DATA_W-1:0]                               rd_data
);

   logic [DATA_W-1:0] mem [RAM_DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

@@ design/dqm_div.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// dqm_div : serial restoring divider
// Produces one quotient bit per cycle; done pulses for one cycle at the end.
// ----------------------------------------------------------------------------
module dqm_div
   import dqm_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire logic [DIVD_W-1:0] dividend,
   input  wire logic [CNT_W-1:0]  divisor,
   output logic                   done,
   output logic      [DIVD_W-1:0] quotient
);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [DIVD_W-1:0] quo_ff, quo_in;
   logic [CNT_W:0]    rem_ff, rem_in;
   logic [CNT_W-1:0]  dsr_ff, dsr_in;
   logic [CNT_W:0]    trial;
   logic              fits;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      // bring down the next dividend bit and try the subtraction
      trial   = {rem_ff[CNT_W-1:0], quo_ff[DIVD_W-1]};
      fits    = (trial >= {1'b0, dsr_ff});
      if (start) begin
         busy_in = 1'b1;
         step_in = STEP_W'(DIVD_W);
         quo_in  = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
      end else if (busy_ff) begin
         rem_in  = fits ? (trial - {1'b0, dsr_ff}) : trial;
         quo_in  = {quo_ff[DIVD_W-2:0], fits};
         step_in = step_ff - STEP_W'(1);
         if (step_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule
`default_nettype wire
